>>> rtl/two_way_lru_writeback_cache_model_macros.svh
// Assertion helpers for the cache model. Empty when SYNTH is defined.
`ifndef TWO_WAY_LRU_WRITEBACK_CACHE_MODEL_MACROS_SVH
`define TWO_WAY_LRU_WRITEBACK_CACHE_MODEL_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TWLWC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TWLWC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TWLWC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define TWLWC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

>>> rtl/twlwc_pkg.sv
`default_nettype none

package twlwc_pkg;

    localparam int SET_BITS    = 5;
    localparam int OFFSET_BITS = 4;
    localparam int ADDR_BITS   = 20;
    localparam int TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;
    localparam int NUM_SETS    = 1 << SET_BITS;

    localparam int HL_BITS     = 8;
    localparam int RD_BITS     = 8;
    localparam int ML_BITS     = 10;
    localparam int TICK_BITS   = 12;
    localparam int TOTAL_BITS  = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HIT_LATENCY    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REQUEST_DELAY  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEMORY_LATENCY = 2'd2;

    localparam logic [HL_BITS-1:0] HIT_LATENCY_RST    = 8'd6;
    localparam logic [RD_BITS-1:0] REQUEST_DELAY_RST  = 8'd4;
    localparam logic [ML_BITS-1:0] MEMORY_LATENCY_RST = 10'd100;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    typedef struct packed {
        logic accept;   // take the input word, start the tag read
        logic commit;   // update the set and load the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free; // output register empty or being drained this cycle
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/two_way_lru_writeback_cache_model.sv
// Channel  Handshake              Payload
// -------  ---------------------  --------------------------------------------
// in       in_valid / in_stall    cmd, address
// out      out_valid / out_stall  hit, way, writeback, access_ticks,
//                                 total_ticks, access_count, hit_count
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each access is a tag RAM read (registered read port), then the set update
// and output register load. No new word is taken before the last is committed.
// A finished word waits in the output register; a new word is taken meanwhile,
// and its update holds only while the previous word is still stalled.
// rst_n clears all tag valid/dirty/LRU bits and the totals, and loads the
// default configuration.
`default_nettype none

`include "two_way_lru_writeback_cache_model_macros.svh"

module two_way_lru_writeback_cache_model (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [twlwc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [twlwc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                cmd,
    input  wire logic [twlwc_pkg::ADDR_BITS-1:0]     address,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     hit,
    output logic                                     way,
    output logic                                     writeback,
    output logic      [twlwc_pkg::TICK_BITS-1:0]     access_ticks,
    output logic      [twlwc_pkg::TOTAL_BITS-1:0]    total_ticks,
    output logic      [twlwc_pkg::TOTAL_BITS-1:0]    access_count,
    output logic      [twlwc_pkg::TOTAL_BITS-1:0]    hit_count
);

    twlwc_pkg::ctrl_cmd_t  ctrl_cmd;
    twlwc_pkg::dp_status_t dp_status;

    logic in_take;
    logic word_shown;
    logic hits_ok;
    logic hit_shown;

    assign cfg_ready = 1'b1;

    twlwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    twlwc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .status       (dp_status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_cmd       (cmd),
        .in_address   (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .way          (way),
        .writeback    (writeback),
        .access_ticks (access_ticks),
        .total_ticks  (total_ticks),
        .access_count (access_count),
        .hit_count    (hit_count)
    );

    assign in_take    = in_valid && !in_stall;
    assign word_shown = out_valid && (access_count != '0);
    assign hits_ok    = hit_count <= access_count;
    assign hit_shown  = out_valid && hit;

    `TWLWC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_take, in_stall, "accept while busy")
    `TWLWC_ASSERT_NXT(a_commit_shows_word, clk, rst_n, ctrl_cmd.commit, word_shown, "no word")
    `TWLWC_ASSERT_IMP(a_hits_le_accesses, clk, rst_n, out_valid, hits_ok, "hits above accesses")
    `TWLWC_ASSERT_IMP(a_hit_no_writeback, clk, rst_n, hit_shown, !writeback, "write-back on hit")

endmodule

`default_nettype wire

>>> rtl/twlwc_ram.sv
`default_nettype none

module twlwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/twlwc_ctrl.sv
`default_nettype none

module twlwc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire twlwc_pkg::dp_status_t status,
    output twlwc_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // hold the looked-up set until the output register can take the word
                cmd.commit = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/twlwc_dp.sv
`default_nettype none

module twlwc_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire twlwc_pkg::ctrl_cmd_t                   cmd,
    output twlwc_pkg::dp_status_t                       status,
    input  wire logic                                   cfg_we,
    input  wire logic [twlwc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [twlwc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                   in_cmd,
    input  wire logic [twlwc_pkg::ADDR_BITS-1:0]        in_address,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        hit,
    output logic                                        way,
    output logic                                        writeback,
    output logic      [twlwc_pkg::TICK_BITS-1:0]        access_ticks,
    output logic      [twlwc_pkg::TOTAL_BITS-1:0]       total_ticks,
    output logic      [twlwc_pkg::TOTAL_BITS-1:0]       access_count,
    output logic      [twlwc_pkg::TOTAL_BITS-1:0]       hit_count
);

    localparam int SB = twlwc_pkg::SET_BITS;
    localparam int TB = twlwc_pkg::TAG_BITS;
    localparam int NS = twlwc_pkg::NUM_SETS;
    localparam int TW = twlwc_pkg::TOTAL_BITS;
    localparam int KB = twlwc_pkg::TICK_BITS;

    // configuration
    logic [twlwc_pkg::HL_BITS-1:0] hit_latency_reg;
    logic [twlwc_pkg::RD_BITS-1:0] request_delay_reg;
    logic [twlwc_pkg::ML_BITS-1:0] memory_latency_reg;

    // captured request
    logic                            cmd_reg;
    logic [twlwc_pkg::ADDR_BITS-1:0] addr_reg;

    // per-set flags
    logic [NS-1:0] valid0_reg, valid1_reg, valid0_next, valid1_next;
    logic [NS-1:0] dirty0_reg, dirty1_reg, dirty0_next, dirty1_next;
    logic [NS-1:0] lru_reg, lru_next;

    logic [TW-1:0] tick_total_reg, tick_total_next;
    logic [TW-1:0] access_total_reg, access_total_next;
    logic [TW-1:0] hit_total_reg, hit_total_next;

    logic out_valid_reg, out_valid_next;
    logic hit_reg, way_reg, wb_reg;
    logic [KB-1:0] ticks_reg;

    logic [SB-1:0] rd_set, set_q;
    logic [TB-1:0] tag_q, tag0, tag1;
    logic          hit0, hit1, hit_c, way_c, wb_c, victim_dirty;
    logic [KB-1:0] ticks_c;
    logic [TW:0]   tick_sum;
    logic          we0, we1;

    assign rd_set = in_address[twlwc_pkg::OFFSET_BITS +: SB];
    assign set_q  = addr_reg[twlwc_pkg::OFFSET_BITS +: SB];
    assign tag_q  = addr_reg[twlwc_pkg::ADDR_BITS-1 -: TB];

    twlwc_ram #(.WIDTH(TB), .DEPTH(NS)) u_tag0 (
        .clk   (clk),
        .we    (we0),
        .waddr (set_q),
        .wdata (tag_q),
        .re    (cmd.accept),
        .raddr (rd_set),
        .rdata (tag0)
    );

    twlwc_ram #(.WIDTH(TB), .DEPTH(NS)) u_tag1 (
        .clk   (clk),
        .we    (we1),
        .waddr (set_q),
        .wdata (tag_q),
        .re    (cmd.accept),
        .raddr (rd_set),
        .rdata (tag1)
    );

    // an invalid entry never matches, so its unwritten tag is harmless
    assign hit0  = valid0_reg[set_q] && (tag0 == tag_q);
    assign hit1  = valid1_reg[set_q] && (tag1 == tag_q);
    assign hit_c = hit0 || hit1;
    assign way_c = hit0 ? 1'b0 : (hit1 ? 1'b1 : lru_reg[set_q]);
    assign victim_dirty = way_c ? dirty1_reg[set_q] : dirty0_reg[set_q];
    assign wb_c  = !hit_c && victim_dirty;

    always_comb
    begin
        ticks_c = KB'(hit_latency_reg);
        if (!hit_c)
        begin
            ticks_c = ticks_c + KB'(request_delay_reg) + KB'(memory_latency_reg);
        end
        if (wb_c)
        begin
            ticks_c = ticks_c + KB'(memory_latency_reg);
        end
    end

    assign we0 = cmd.commit && !hit_c && !way_c;
    assign we1 = cmd.commit && !hit_c && way_c;

    assign tick_sum = {1'b0, tick_total_reg} + (TW + 1)'(ticks_c);

    always_comb
    begin
        valid0_next       = valid0_reg;
        valid1_next       = valid1_reg;
        dirty0_next       = dirty0_reg;
        dirty1_next       = dirty1_reg;
        lru_next          = lru_reg;
        tick_total_next   = tick_total_reg;
        access_total_next = access_total_reg;
        hit_total_next    = hit_total_reg;
        if (cmd.commit)
        begin
            if (way_c)
            begin
                valid1_next[set_q] = 1'b1;
                dirty1_next[set_q] = hit_c ? (dirty1_reg[set_q] || cmd_reg) : cmd_reg;
            end
            else
            begin
                valid0_next[set_q] = 1'b1;
                dirty0_next[set_q] = hit_c ? (dirty0_reg[set_q] || cmd_reg) : cmd_reg;
            end
            lru_next[set_q] = !way_c;
            tick_total_next = tick_sum[TW] ? twlwc_pkg::TOTAL_MAX : tick_sum[TW-1:0];
            if (access_total_reg != twlwc_pkg::TOTAL_MAX)
            begin
                access_total_next = access_total_reg + TW'(1);
            end
            if (hit_c && (hit_total_reg != twlwc_pkg::TOTAL_MAX))
            begin
                hit_total_next = hit_total_reg + TW'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_latency_reg    <= twlwc_pkg::HIT_LATENCY_RST;
            request_delay_reg  <= twlwc_pkg::REQUEST_DELAY_RST;
            memory_latency_reg <= twlwc_pkg::MEMORY_LATENCY_RST;
            valid0_reg         <= '0;
            valid1_reg         <= '0;
            dirty0_reg         <= '0;
            dirty1_reg         <= '0;
            lru_reg            <= '0;
            tick_total_reg     <= '0;
            access_total_reg   <= '0;
            hit_total_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    twlwc_pkg::CFG_HIT_LATENCY:
                    begin
                        hit_latency_reg <= cfg_data[twlwc_pkg::HL_BITS-1:0];
                    end
                    twlwc_pkg::CFG_REQUEST_DELAY:
                    begin
                        request_delay_reg <= cfg_data[twlwc_pkg::RD_BITS-1:0];
                    end
                    twlwc_pkg::CFG_MEMORY_LATENCY:
                    begin
                        memory_latency_reg <= cfg_data[twlwc_pkg::ML_BITS-1:0];
                    end
                    default:
                    begin
                        // unmapped index, ignored
                    end
                endcase
            end
            valid0_reg       <= valid0_next;
            valid1_reg       <= valid1_next;
            dirty0_reg       <= dirty0_next;
            dirty1_reg       <= dirty1_next;
            lru_reg          <= lru_next;
            tick_total_reg   <= tick_total_next;
            access_total_reg <= access_total_next;
            hit_total_reg    <= hit_total_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= in_cmd;
            addr_reg <= in_address;
        end
        if (cmd.commit)
        begin
            hit_reg   <= hit_c;
            way_reg   <= way_c;
            wb_reg    <= wb_c;
            ticks_reg <= ticks_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign way          = way_reg;
    assign writeback    = wb_reg;
    assign access_ticks = ticks_reg;
    assign total_ticks  = tick_total_reg;
    assign access_count = access_total_reg;
    assign hit_count    = hit_total_reg;

endmodule

`default_nettype wire

>>> sim/cache_access_checker.sv
`timescale 1ns / 1ps

module cache_access_checker
    import twlwc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic                     cmd,
    input  wire logic [ADDR_BITS-1:0]     address,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic                     hit,
    input  wire logic                     way,
    input  wire logic                     writeback,
    input  wire logic [TICK_BITS-1:0]     access_ticks,
    input  wire logic [TOTAL_BITS-1:0]    total_ticks,
    input  wire logic [TOTAL_BITS-1:0]    access_count,
    input  wire logic [TOTAL_BITS-1:0]    hit_count,
    output logic      [31:0]              mismatch_count,
    output logic      [31:0]              outstanding
);

    typedef struct packed {
        logic                  hit;
        logic                  way;
        logic                  writeback;
        logic [TICK_BITS-1:0]  ticks;
        logic [TOTAL_BITS-1:0] tick_sum;
        logic [TOTAL_BITS-1:0] accesses;
        logic [TOTAL_BITS-1:0] hits;
    } access_outcome_t;

    // line index is {set, way}
    logic [TAG_BITS-1:0]   line_tag   [0:2*NUM_SETS-1];
    logic                  line_valid [0:2*NUM_SETS-1];
    logic                  line_dirty [0:2*NUM_SETS-1];
    logic                  next_victim [0:NUM_SETS-1];
    logic [TOTAL_BITS-1:0] tick_sum;
    logic [TOTAL_BITS-1:0] access_sum;
    logic [TOTAL_BITS-1:0] hit_sum;

    logic [HL_BITS-1:0]    hit_latency;
    logic [RD_BITS-1:0]    request_delay;
    logic [ML_BITS-1:0]    memory_latency;

    access_outcome_t       predicted_outcomes [$];

    function automatic logic [TOTAL_BITS-1:0] sat_add(input logic [TOTAL_BITS-1:0] a,
                                                       input logic [TOTAL_BITS-1:0] b);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_BITS] ? TOTAL_MAX : s[TOTAL_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %0h actual %0h", $realtime, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    task automatic predict_access(input logic is_write, input logic [ADDR_BITS-1:0] addr);
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_BITS-1:0] tag;
        logic                found;
        logic                w;
        logic                wb;
        logic [31:0]         ticks;
        access_outcome_t     o;
        set_idx = addr[OFFSET_BITS +: SET_BITS];
        tag     = addr[ADDR_BITS-1 -: TAG_BITS];
        ticks   = 32'(hit_latency);
        found   = 1'b0;
        w       = 1'b0;
        wb      = 1'b0;
        if (line_valid[{set_idx, 1'b0}] && line_tag[{set_idx, 1'b0}] == tag)
        begin
            found = 1'b1;
            w     = 1'b0;
        end
        else if (line_valid[{set_idx, 1'b1}] && line_tag[{set_idx, 1'b1}] == tag)
        begin
            found = 1'b1;
            w     = 1'b1;
        end
        if (found)
        begin
            if (is_write)
                line_dirty[{set_idx, w}] = 1'b1;
        end
        else
        begin
            w     = next_victim[set_idx];
            ticks = ticks + 32'(request_delay) + 32'(memory_latency);
            // an invalid line is never dirty, so no write-back for it
            if (line_dirty[{set_idx, w}])
            begin
                wb    = 1'b1;
                ticks = ticks + 32'(memory_latency);
            end
            line_valid[{set_idx, w}] = 1'b1;
            line_tag[{set_idx, w}]   = tag;
            line_dirty[{set_idx, w}] = is_write;
        end
        next_victim[set_idx] = ~w;
        access_sum = sat_add(access_sum, 32'd1);
        if (found)
            hit_sum = sat_add(hit_sum, 32'd1);
        tick_sum = sat_add(tick_sum, ticks);
        o.hit       = found;
        o.way       = w;
        o.writeback = wb;
        o.ticks     = ticks[TICK_BITS-1:0];
        o.tick_sum  = tick_sum;
        o.accesses  = access_sum;
        o.hits      = hit_sum;
        predicted_outcomes.push_back(o);
    endtask

    task automatic compare_result();
        access_outcome_t want;
        if (predicted_outcomes.size() == 0)
        begin
            report_mismatch("word with nothing expected, access_count", 32'd0, access_count);
            return;
        end
        want = predicted_outcomes.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("way", 32'(want.way), 32'(way));
        check_field("writeback", 32'(want.writeback), 32'(writeback));
        check_field("access_ticks", 32'(want.ticks), 32'(access_ticks));
        check_field("total_ticks", want.tick_sum, total_ticks);
        check_field("access_count", want.accesses, access_count);
        check_field("hit_count", want.hits, hit_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2*NUM_SETS; i++)
            begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
            end
            for (int i = 0; i < NUM_SETS; i++)
                next_victim[i] = 1'b0;
            tick_sum       = '0;
            access_sum     = '0;
            hit_sum        = '0;
            hit_latency    = HIT_LATENCY_RST;
            request_delay  = REQUEST_DELAY_RST;
            memory_latency = MEMORY_LATENCY_RST;
            mismatch_count = '0;
            predicted_outcomes.delete();
            outstanding <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HIT_LATENCY:    hit_latency    = cfg_data[HL_BITS-1:0];
                    CFG_REQUEST_DELAY:  request_delay  = cfg_data[RD_BITS-1:0];
                    CFG_MEMORY_LATENCY: memory_latency = cfg_data[ML_BITS-1:0];
                    default: ;
                endcase
            end
            // older word leaves before the new one is predicted
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall)
                predict_access(cmd, address);
            outstanding <= 32'(predicted_outcomes.size());
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import twlwc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 205;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = 1'b0;
    logic [ADDR_BITS-1:0]     address = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     hit;
    logic                     way;
    logic                     writeback;
    logic [TICK_BITS-1:0]     access_ticks;
    logic [TOTAL_BITS-1:0]    total_ticks;
    logic [TOTAL_BITS-1:0]    access_count;
    logic [TOTAL_BITS-1:0]    hit_count;

    logic [31:0]              mismatch_count;
    logic [31:0]              outstanding;
    logic [31:0]              cycle_count = '0;
    logic                     calm = 1'b0;
    logic [3:0]               stall_left = '0;
    logic [TAG_BITS-1:0]      tag_pool [0:3];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_way_lru_writeback_cache_model uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .way          (way),
        .writeback    (writeback),
        .access_ticks (access_ticks),
        .total_ticks  (total_ticks),
        .access_count (access_count),
        .hit_count    (hit_count)
    );

    cache_access_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .way            (way),
        .writeback      (writeback),
        .access_ticks   (access_ticks),
        .total_ticks    (total_ticks),
        .access_count   (access_count),
        .hit_count      (hit_count),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 32'd1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 4'd1;
            out_stall  <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= 4'($urandom_range(0, 11));
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // valid is left high after acceptance; the next call or a gap decides
    task automatic issue(input logic c, input logic [ADDR_BITS-1:0] a);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        address  <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic issue_random();
        logic [ADDR_BITS-1:0] a;
        a = ADDR_BITS'($urandom);
        // mostly a few tags per set, so lines get hit, evicted and written back
        if ($urandom_range(0, 9) < 8)
            a[ADDR_BITS-1 -: TAG_BITS] = tag_pool[$urandom_range(0, 3)];
        issue(1'($urandom_range(0, 1)), a);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_timing(input logic [HL_BITS-1:0] hl, input logic [RD_BITS-1:0] rd,
                              input logic [ML_BITS-1:0] ml);
        // upper data bits are junk for the 8-bit registers
        cfg_put(CFG_HIT_LATENCY, 32'(hl) | ($urandom_range(0, 3) << HL_BITS));
        cfg_put(CFG_UNUSED, $urandom);
        cfg_put(CFG_REQUEST_DELAY, 32'(rd) | ($urandom_range(0, 3) << RD_BITS));
        cfg_put(CFG_MEMORY_LATENCY, 32'(ml));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // set 0: cold miss on tag zero, hits, then evictions clean and dirty
        issue(CMD_READ,  20'h00000);
        issue(CMD_READ,  20'h00004);
        issue(CMD_WRITE, 20'h0000C);
        issue(CMD_READ,  20'h00200);
        issue(CMD_READ,  20'h00000);
        issue(CMD_WRITE, 20'h00400);
        issue(CMD_READ,  20'h00600);
        issue(CMD_READ,  20'h00800);
        issue(CMD_WRITE, 20'h00600);
        issue(CMD_READ,  20'h00808);
        // set 31, top of the address range
        issue(CMD_READ,  20'hFFFFF);
        issue(CMD_WRITE, 20'hFFFF0);
        issue(CMD_WRITE, 20'h7FFF0);
        issue(CMD_READ,  20'h001F0);
        issue(CMD_READ,  20'hFFFF8);
        // set 1: write misses into invalid lines, then dirty evictions
        issue(CMD_WRITE, 20'h00010);
        issue(CMD_WRITE, 20'h00210);
        issue(CMD_WRITE, 20'h00410);
        issue(CMD_READ,  20'h00010);
        issue(CMD_READ,  20'h00610);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p == NUM_PHASES - 1)
                calm <= 1'b1;
            for (int k = 0; k < 4; k++)
                tag_pool[k] = TAG_BITS'($urandom);
            case (p)
                0: set_timing(8'd0, 8'd0, 10'd0);
                1: set_timing(8'd255, 8'd255, 10'd1023);
                2: set_timing(8'd255, 8'd0, 10'd1023);
                NUM_PHASES - 1: set_timing(HIT_LATENCY_RST, REQUEST_DELAY_RST,
                                           MEMORY_LATENCY_RST);
                default: set_timing(HL_BITS'($urandom), RD_BITS'($urandom),
                                    ML_BITS'($urandom));
            endcase
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                // sender holds off until everything in flight has come back
                if (p == 3 && i == WORDS_PER_PHASE / 2)
                    drain();
                issue_random();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
